FILE: hdl/sign_lms_audio_reconstruction_filter_assert.svh
// Assertion macros used by the sign-LMS reconstruction filter module.
`ifndef SIGN_LMS_AUDIO_RECONSTRUCTION_FILTER_ASSERT_SVH
`define SIGN_LMS_AUDIO_RECONSTRUCTION_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SLARF_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sign-LMS filter check failed");
`define SLARF_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sign-LMS filter check failed");
`else
`define SLARF_ASSERT_RST(lbl, clk, rst, prop)
`define SLARF_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

FILE: hdl/slarf_pkg.sv
// Shared constants and types of the sign-LMS reconstruction filter.
package slarf_pkg;

  localparam int MAX_ORDER = 1280;
  localparam int MIN_ORDER = 16;
  localparam int ADDR_W    = $clog2(MAX_ORDER);
  localparam int CNT_W     = $clog2(MAX_ORDER + 1);
  localparam int POS_W     = ADDR_W + 2;
  localparam int ORDER_W   = 11;
  localparam int FRAC_W    = 4;
  localparam int CMP_W     = (ORDER_W > CNT_W) ? ORDER_W : CNT_W;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int HIST_W    = 16;
  localparam int ADAPT_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_MODE   = 2'd2;

  localparam logic [ORDER_W-1:0] RESET_ORDER = 11'd16;
  localparam logic [FRAC_W-1:0]  RESET_FRAC  = 4'd11;
  localparam logic               RESET_MODE  = 1'b1;

  localparam logic MODE_OLD = 1'b0;
  localparam logic MODE_NEW = 1'b1;

  localparam logic signed [ADAPT_W-1:0] ADAPT_LARGE = 7'sd32;
  localparam logic signed [ADAPT_W-1:0] ADAPT_MID   = 7'sd16;
  localparam logic signed [ADAPT_W-1:0] ADAPT_SMALL = 7'sd8;
  localparam logic signed [ADAPT_W-1:0] ADAPT_OLD   = 7'sd4;

  localparam logic [3:0] AGE_NEW_0 = 4'd1;
  localparam logic [3:0] AGE_NEW_1 = 4'd2;
  localparam logic [3:0] AGE_NEW_2 = 4'd8;
  localparam logic [3:0] AGE_OLD_0 = 4'd4;
  localparam logic [3:0] AGE_OLD_1 = 4'd8;

  typedef struct packed {
    logic issue;
    logic clr_acc;
    logic neg;
    logic upd;
  } mac_ctrl_t;

endpackage

FILE: hdl/slarf_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module slarf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1280
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/slarf_mac.sv
// Shared multiply-accumulate unit with the per-tap coefficient update.
module slarf_mac (
  input  logic                                         clk,
  input  logic                                         rst,
  input  slarf_pkg::mac_ctrl_t                         ctrl,
  input  logic [slarf_pkg::ADDR_W-1:0]                 tap_index,
  input  logic [slarf_pkg::COEF_W-1:0]                 coef_q,
  input  logic [slarf_pkg::HIST_W-1:0]                 hist_q,
  input  logic [slarf_pkg::ADAPT_W-1:0]                adapt_q,
  output logic                                         coef_we,
  output logic [slarf_pkg::ADDR_W-1:0]                 coef_waddr,
  output logic [slarf_pkg::COEF_W-1:0]                 coef_wdata,
  output logic [slarf_pkg::DATA_W-1:0]                 acc,
  output logic                                         busy
);

  logic                            v1;
  logic                            v2;
  logic [slarf_pkg::ADDR_W-1:0]    idx1;
  logic signed [slarf_pkg::DATA_W-1:0] prod;
  logic [slarf_pkg::COEF_W-1:0]    adapt_ext;

  assign adapt_ext = {{(slarf_pkg::COEF_W - slarf_pkg::ADAPT_W){adapt_q[slarf_pkg::ADAPT_W-1]}},
                      adapt_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      if (ctrl.clr_acc) begin
        acc <= '0;
      end else if (v2) begin
        acc <= acc + prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= tap_index;
    if (v1) begin
      prod <= $signed(hist_q) * $signed(coef_q);
    end
  end

  assign coef_we    = v1 && ctrl.upd;
  assign coef_waddr = idx1;
  assign coef_wdata = ctrl.neg ? (coef_q + adapt_ext) : (coef_q - adapt_ext);
  assign busy       = v1 || v2;

endmodule

FILE: hdl/sign_lms_audio_reconstruction_filter.sv
// Sign-LMS audio reconstruction filter: sequencer, state memories and post-processing.
// filter_order is held to 16..1280 as the tap count N; clear_first first runs a clearing pass over
// all 1280 addresses of the state memories before the item is processed.
// One tap per cycle goes through the single shared multiply-accumulate unit, and the next item
// can be taken in the same cycle that the result is shown; only one item is in flight at a time.
// Synchronous reset starts the same clearing pass, during which no item is taken.
module sign_lms_audio_reconstruction_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,   // [31:0] sample_in
  input  logic                                s_axis_tuser,   // [0] clear_first
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,   // [31:0] sample_out
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [slarf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slarf_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW = slarf_pkg::ADDR_W;
  localparam int CW = slarf_pkg::CNT_W;
  localparam int PW = slarf_pkg::POS_W;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_START = 13'b0000000000100,
    S_TAP   = 13'b0000000001000,
    S_DRAIN = 13'b0000000010000,
    S_ROUND = 13'b0000000100000,
    S_SUM   = 13'b0000001000000,
    S_ABS   = 13'b0000010000000,
    S_CMP   = 13'b0000100000000,
    S_AVG   = 13'b0001000000000,
    S_HRD   = 13'b0010000000000,
    S_HWR   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [slarf_pkg::ORDER_W-1:0] filter_order;
  logic [slarf_pkg::FRAC_W-1:0]  frac_bits;
  logic                          adapt_mode;

  logic                          pending;
  logic signed [31:0]            sample;
  logic                          last_flag;
  logic [AW-1:0]                 clr_addr;
  logic [AW-1:0]                 head;
  logic [AW-1:0]                 pos;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 order_eff;
  logic signed [31:0]            acc_r;
  logic signed [31:0]            res;
  logic [32:0]                   absres;
  logic [31:0]                   avg;
  logic [1:0]                    hstep;
  logic [AW-1:0]                 haddr;

  logic [CW-1:0]                 order_clamp;
  logic [slarf_pkg::CMP_W-1:0]   fo_ext;
  logic [PW-1:0]                 start_sum;
  logic [AW-1:0]                 head_inc;
  logic [AW-1:0]                 pos_inc;
  logic                          tap_last;
  logic [31:0]                   rnd;
  logic [15:0]                   clip;
  logic [33:0]                   avg3;
  logic [34:0]                   abs3;
  logic                          big;
  logic                          mid;
  logic signed [6:0]             nv;
  logic signed [33:0]            diff;
  logic signed [33:0]            diff_adj;
  logic signed [33:0]            quot;
  logic [3:0]                    age;
  logic                          hlast;
  logic [AW-1:0]                 hpos;
  logic [6:0]                    halved;
  logic                          out_load;

  slarf_pkg::mac_ctrl_t          mac_ctrl;
  logic                          mac_coef_we;
  logic [AW-1:0]                 mac_coef_waddr;
  logic [15:0]                   mac_coef_wdata;
  logic [31:0]                   mac_acc;
  logic                          mac_busy;

  logic                          coef_we;
  logic [AW-1:0]                 coef_waddr;
  logic [15:0]                   coef_wdata;
  logic [15:0]                   coef_q;
  logic                          hist_we;
  logic [AW-1:0]                 hist_waddr;
  logic [15:0]                   hist_wdata;
  logic [15:0]                   hist_q;
  logic                          adapt_we;
  logic [AW-1:0]                 adapt_waddr;
  logic [6:0]                    adapt_wdata;
  logic [AW-1:0]                 adapt_raddr;
  logic [6:0]                    adapt_q;

  // Effective order, start position of the oldest tap and ring pointer steps.
  assign fo_ext = slarf_pkg::CMP_W'(filter_order);
  always_comb begin
    if (fo_ext < slarf_pkg::CMP_W'(slarf_pkg::MIN_ORDER)) begin
      order_clamp = CW'(slarf_pkg::MIN_ORDER);
    end else if (fo_ext > slarf_pkg::CMP_W'(slarf_pkg::MAX_ORDER)) begin
      order_clamp = CW'(slarf_pkg::MAX_ORDER);
    end else begin
      order_clamp = CW'(fo_ext);
    end
  end

  assign start_sum = PW'(head) + PW'(slarf_pkg::MAX_ORDER + 1) - PW'(order_clamp);
  assign head_inc  = (head == AW'(slarf_pkg::MAX_ORDER - 1)) ? '0 : head + 1'b1;
  assign pos_inc   = (pos == AW'(slarf_pkg::MAX_ORDER - 1)) ? '0 : pos + 1'b1;
  assign tap_last  = (cnt + 1'b1) == order_eff;

  // Rounding, clipping and adaption decisions.
  assign rnd = (frac_bits != '0) ? (32'd1 << (frac_bits - 1'b1)) : '0;

  always_comb begin
    if (res > 32'sd32767) begin
      clip = 16'h7fff;
    end else if (res < -32'sd32768) begin
      clip = 16'h8000;
    end else begin
      clip = res[15:0];
    end
  end

  assign avg3 = {2'b00, avg} + {1'b0, avg, 1'b0};
  assign abs3 = {2'b00, absres} + {1'b0, absres, 1'b0};
  assign big  = {1'b0, absres} > avg3;
  assign mid  = abs3 > {1'b0, avg, 2'b00};

  always_comb begin
    if (adapt_mode == slarf_pkg::MODE_OLD) begin
      if (res == '0) begin
        nv = '0;
      end else begin
        nv = res[31] ? slarf_pkg::ADAPT_OLD : -slarf_pkg::ADAPT_OLD;
      end
    end else if (big) begin
      nv = res[31] ? slarf_pkg::ADAPT_LARGE : -slarf_pkg::ADAPT_LARGE;
    end else if (mid) begin
      nv = res[31] ? slarf_pkg::ADAPT_MID : -slarf_pkg::ADAPT_MID;
    end else if (absres != '0) begin
      nv = res[31] ? slarf_pkg::ADAPT_SMALL : -slarf_pkg::ADAPT_SMALL;
    end else begin
      nv = '0;
    end
  end

  assign diff     = $signed({1'b0, absres}) - $signed({2'b00, avg});
  assign diff_adj = diff[33] ? (diff + 34'sd15) : diff;
  assign quot     = diff_adj >>> 4;

  // Ages of the adaption values halved after each item.
  always_comb begin
    age   = slarf_pkg::AGE_NEW_0;
    hlast = 1'b0;
    if (adapt_mode == slarf_pkg::MODE_NEW) begin
      case (hstep)
        2'd0: age = slarf_pkg::AGE_NEW_0;
        2'd1: age = slarf_pkg::AGE_NEW_1;
        default: begin
          age   = slarf_pkg::AGE_NEW_2;
          hlast = 1'b1;
        end
      endcase
    end else begin
      case (hstep)
        2'd0: age = slarf_pkg::AGE_OLD_0;
        default: begin
          age   = slarf_pkg::AGE_OLD_1;
          hlast = 1'b1;
        end
      endcase
    end
  end

  assign hpos   = (head >= AW'(age)) ? (head - AW'(age))
                                     : (head + AW'(slarf_pkg::MAX_ORDER) - AW'(age));
  assign halved = {adapt_q[6], adapt_q[6:1]};

  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= slarf_pkg::RESET_ORDER;
      frac_bits    <= slarf_pkg::RESET_FRAC;
      adapt_mode   <= slarf_pkg::RESET_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        slarf_pkg::REG_FILTER_ORDER: filter_order <= cfg_wdata[slarf_pkg::ORDER_W-1:0];
        slarf_pkg::REG_FRAC_BITS:    frac_bits    <= cfg_wdata[slarf_pkg::FRAC_W-1:0];
        slarf_pkg::REG_ADAPT_MODE:   adapt_mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      pending       <= 1'b0;
      clr_addr      <= '0;
      head          <= '0;
      avg           <= '0;
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
      hstep         <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          avg <= '0;
          if (clr_addr == AW'(slarf_pkg::MAX_ORDER - 1)) begin
            clr_addr <= '0;
            state    <= pending ? S_START : S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pending <= s_axis_tuser;
            state   <= s_axis_tuser ? S_CLEAR : S_START;
          end
        end
        S_START: begin
          pending <= 1'b0;
          cnt     <= '0;
          state   <= S_TAP;
        end
        S_TAP: begin
          cnt <= cnt + 1'b1;
          if (tap_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: state <= S_SUM;
        S_SUM: begin
          head  <= head_inc;
          state <= S_ABS;
        end
        S_ABS: state <= S_CMP;
        S_CMP: begin
          hstep <= '0;
          state <= S_AVG;
        end
        S_AVG: begin
          if (adapt_mode == slarf_pkg::MODE_NEW) begin
            avg <= avg + quot[31:0];
          end
          state <= S_HRD;
        end
        S_HRD: state <= S_HWR;
        S_HWR: begin
          hstep <= hstep + 1'b1;
          state <= hlast ? S_OUT : S_HRD;
        end
        S_OUT: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample    <= s_axis_tdata;
      last_flag <= s_axis_tlast;
    end
    if (state == S_START) begin
      order_eff <= order_clamp;
    end
    if (state == S_TAP && cnt == '0) begin
      pos <= pos_inc;
    end else if (state == S_TAP) begin
      pos <= pos_inc;
    end else if (state == S_START) begin
      pos <= (start_sum >= PW'(slarf_pkg::MAX_ORDER)) ?
             AW'(start_sum - PW'(slarf_pkg::MAX_ORDER)) : AW'(start_sum);
    end
    if (state == S_ROUND) begin
      acc_r <= mac_acc + rnd;
    end
    if (state == S_SUM) begin
      res <= (acc_r >>> frac_bits) + sample;
    end
    if (state == S_ABS) begin
      absres <= res[31] ? (33'd0 - {res[31], res}) : {1'b0, res};
    end
    if (state == S_HRD) begin
      haddr <= hpos;
    end
    if (out_load) begin
      m_axis_tdata <= res;
      m_axis_tlast <= last_flag;
    end
  end

  // Taps issue after S_START sets the start position; the sample sign steers the coefficient update.
  always_comb begin
    mac_ctrl.issue   = (state == S_TAP);
    mac_ctrl.clr_acc = (state == S_START);
    mac_ctrl.neg     = sample[31];
    mac_ctrl.upd     = (sample != '0);
  end

  slarf_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .tap_index  (cnt[AW-1:0]),
    .coef_q     (coef_q),
    .hist_q     (hist_q),
    .adapt_q    (adapt_q),
    .coef_we    (mac_coef_we),
    .coef_waddr (mac_coef_waddr),
    .coef_wdata (mac_coef_wdata),
    .acc        (mac_acc),
    .busy       (mac_busy)
  );

  // Memory port selection.
  always_comb begin
    if (state == S_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = clr_addr;
      coef_wdata = '0;
    end else begin
      coef_we    = mac_coef_we;
      coef_waddr = mac_coef_waddr;
      coef_wdata = mac_coef_wdata;
    end
  end

  assign hist_we    = (state == S_CLEAR) || (state == S_ABS);
  assign hist_waddr = (state == S_CLEAR) ? clr_addr : head;
  assign hist_wdata = (state == S_CLEAR) ? '0 : clip;

  always_comb begin
    adapt_we    = 1'b0;
    adapt_waddr = clr_addr;
    adapt_wdata = '0;
    case (state)
      S_CLEAR: adapt_we = 1'b1;
      S_CMP: begin
        adapt_we    = 1'b1;
        adapt_waddr = head;
        adapt_wdata = nv;
      end
      S_HWR: begin
        adapt_we    = 1'b1;
        adapt_waddr = haddr;
        adapt_wdata = halved;
      end
      default: ;
    endcase
  end

  assign adapt_raddr = (state == S_HRD) ? hpos : pos;

  slarf_ram #(.WIDTH(slarf_pkg::COEF_W), .DEPTH(slarf_pkg::MAX_ORDER)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (coef_q)
  );

  slarf_ram #(.WIDTH(slarf_pkg::HIST_W), .DEPTH(slarf_pkg::MAX_ORDER)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (pos),
    .rdata (hist_q)
  );

  slarf_ram #(.WIDTH(slarf_pkg::ADAPT_W), .DEPTH(slarf_pkg::MAX_ORDER)) u_adapt_ram (
    .clk   (clk),
    .we    (adapt_we),
    .waddr (adapt_waddr),
    .wdata (adapt_wdata),
    .raddr (adapt_raddr),
    .rdata (adapt_q)
  );

`include "sign_lms_audio_reconstruction_filter_assert.svh"

  `SLARF_ASSERT_CLK(a_reset_clears_first, clk, rst |=> !s_axis_tready)
  `SLARF_ASSERT_RST(a_one_item_at_a_time, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `SLARF_ASSERT_RST(a_no_result_overwrite, clk, rst, out_load |-> (!m_axis_tvalid || m_axis_tready))
  `SLARF_ASSERT_RST(a_tap_in_range, clk, rst, (state == S_TAP) |-> (cnt < order_eff))

endmodule
